### src/assert_macros.svh
// Assertion macros for the RTL of the matrix-vector multiply block.
// Included by files that carry concurrent checks; empty bodies under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### src/mvm_pkg.sv
// Shared types and constants of the matrix-vector multiply block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int ACC_W       = 48;  // row accumulator width
  localparam int OUT_W       = 32;  // emitted dot product width
  localparam int ROW_OUT_W   = 4;   // out_row width
  localparam int CFG_W       = 5;   // configuration data width
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 1'b1;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_VEC  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                        valid;
    logic [ROW_OUT_W-1:0]        row;
    logic signed [OUT_W-1:0]     value;
    logic                        last;
    logic                        mismatch;
  } result_t;

endpackage

### src/matrix_vector_multiply_top.sv
// Top level of the matrix-vector multiply block: configuration registers,
// front (queue) and back (multiply-accumulate). Uses mvm_pkg, mvm_front, mvm_back.
//
//   Channel   Handshake            Payload
//   input     start / busy         in_req_type, in_row_index, in_col_index,
//                                  in_element_value, in_is_last
//   result    out_valid (strobe)   out_row, out_product_value, out_last_of_run,
//                                  out_length_mismatch
//   config    cfg_we               cfg_index, cfg_wdata
//
// Items pass a two-entry queue; busy is high while it is full. In the back a load
// is written to the weight store when it is popped, and a vector element passes
// the single multiply-accumulate unit that visits one row per cycle. An element marked
// last adds a result pass over the rows in use; results leave one per cycle, through a
// result register that follows the accumulator reads. Reset empties the queue and accumulators and
// sets both registers to their maximum; the weight store keeps its contents.
// The receiver cannot stall: each result stands for one cycle only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module matrix_vector_multiply_top import mvm_pkg::*; #(
  parameter int ROWS       = 16,
  parameter int COLS       = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [3:0]                  in_row_index,
  input  logic [3:0]                  in_col_index,
  input  logic signed [VALUE_BITS-1:0] in_element_value,
  input  logic                        in_is_last,
  output logic                        out_valid,
  output logic [ROW_OUT_W-1:0]        out_row,
  output logic signed [OUT_W-1:0]     out_product_value,
  output logic                        out_last_of_run,
  output logic                        out_length_mismatch,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_wdata
);

  localparam int AW   = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
  localparam int QW   = AW + VALUE_BITS + 2;
  localparam int NR_W = $clog2(ROWS + 1);
  localparam int NC_W = $clog2(COLS + 1);

  // Registers hold the effective counts: zero counts as one, large values clip.
  logic [NR_W-1:0] nrows_r, nrows_nxt;
  logic [NC_W-1:0] ncols_r, ncols_nxt;
  logic            q_pop;
  logic            q_valid;
  logic [QW-1:0]   q_data;
  result_t         res;

  always_comb begin
    nrows_nxt = nrows_r;
    ncols_nxt = ncols_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS_IN_USE: begin
          if (cfg_wdata == '0) begin
            nrows_nxt = NR_W'(1);
          end else if (32'(cfg_wdata) > ROWS) begin
            nrows_nxt = NR_W'(ROWS);
          end else begin
            nrows_nxt = NR_W'(cfg_wdata);
          end
        end
        CFG_COLS_IN_USE: begin
          if (cfg_wdata == '0) begin
            ncols_nxt = NC_W'(1);
          end else if (32'(cfg_wdata) > COLS) begin
            ncols_nxt = NC_W'(COLS);
          end else begin
            ncols_nxt = NC_W'(cfg_wdata);
          end
        end
        default: begin
          nrows_nxt = nrows_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrows_r <= NR_W'(ROWS);
      ncols_r <= NC_W'(COLS);
    end else begin
      nrows_r <= nrows_nxt;
      ncols_r <= ncols_nxt;
    end
  end

  mvm_front #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (in_req_type),
    .row_index    (in_row_index),
    .col_index    (in_col_index),
    .element_value(in_element_value),
    .is_last      (in_is_last),
    .q_pop        (q_pop),
    .q_valid      (q_valid),
    .q_data       (q_data)
  );

  mvm_back #(
    .ROWS      (ROWS),
    .COLS      (COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_data (q_data),
    .q_pop  (q_pop),
    .nrows  (nrows_r),
    .ncols  (ncols_r),
    .res    (res)
  );

  assign out_valid           = res.valid;
  assign out_row             = res.row;
  assign out_product_value   = res.value;
  assign out_last_of_run     = res.last;
  assign out_length_mismatch = res.mismatch;

  // Results of one vector leave back to back, in row order.
  `ASSERT_NEXT(a_rows_in_order, clk, rst_n, out_valid && !out_last_of_run, out_valid && (out_row == ROW_OUT_W'($past(out_row) + 1'b1)))
  // A new run needs at least one more vector element, so a gap follows the last result.
  `ASSERT_NEXT(a_gap_after_run, clk, rst_n, out_valid && out_last_of_run, !out_valid)
  `ASSERT_IMPLY(a_mismatch_zero, clk, rst_n, out_valid && out_length_mismatch, out_product_value == '0)
  // The mismatch flag stays the same across the results of one vector.
  `ASSERT_NEXT(a_flag_steady, clk, rst_n, out_valid && !out_last_of_run, out_length_mismatch == $past(out_length_mismatch))

endmodule

### src/mvm_fifo.sv
// Small item queue between the front and the back of the block.
// Depends on mvm_pkg for its depth and pointer widths.
`timescale 1ns / 1ps

module mvm_fifo import mvm_pkg::*; #(
  parameter int WIDTH = 22
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0]  store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (cnt_r != '0);
  assign dout    = store[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wp_r] <= din;
    end
  end

endmodule

### src/mvm_front.sv
// Front of the block: takes items, sorts loads from vector elements,
// drops out-of-range loads and queues the rest. Uses mvm_pkg and mvm_fifo.
`timescale 1ns / 1ps

module mvm_front import mvm_pkg::*; #(
  parameter int ROWS       = 16,
  parameter int COLS       = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type,
  input  logic [3:0]            row_index,
  input  logic [3:0]            col_index,
  input  logic [VALUE_BITS-1:0] element_value,
  input  logic                  is_last,
  input  logic                  q_pop,
  output logic                  q_valid,
  output logic [1 + ((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1) + VALUE_BITS:0] q_data
);

  localparam int AW = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
  localparam int QW = AW + VALUE_BITS + 2;

  logic          in_range;
  logic          push;
  op_t           op;
  logic [AW-1:0] addr;
  logic [QW-1:0] entry;

  assign in_range = (32'(row_index) < ROWS) && (32'(col_index) < COLS);
  assign op       = req_type ? OP_VEC : OP_LOAD;
  assign addr     = AW'(32'(row_index) * COLS + 32'(col_index));
  // A load outside the weight store is taken but never reaches the back.
  assign push     = start && !busy && ((op == OP_VEC) || in_range);
  assign entry    = {op, addr, element_value, is_last};

  mvm_fifo #(
    .WIDTH(QW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .din  (entry),
    .full (busy),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_data)
  );

endmodule

### src/mvm_back.sv
// Back of the block: weight store, shared multiply-accumulate over the rows,
// and the result pass. Depends on mvm_pkg; fed by the queue in mvm_front.
`timescale 1ns / 1ps

module mvm_back import mvm_pkg::*; #(
  parameter int ROWS       = 16,
  parameter int COLS       = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    q_valid,
  input  logic [1 + ((ROWS*COLS > 1) ? $clog2(ROWS*COLS) : 1) + VALUE_BITS:0] q_data,
  output logic                                    q_pop,
  input  logic [$clog2(ROWS + 1)-1:0]             nrows,
  input  logic [$clog2(COLS + 1)-1:0]             ncols,
  output result_t                                 res
);

  localparam int AW        = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
  localparam int QW        = AW + VALUE_BITS + 2;
  localparam int RIW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W     = $clog2(2 * COLS);
  localparam int COUNT_MAX = 2 * COLS - 1;
  localparam int PW        = 2 * VALUE_BITS;
  localparam int SUM_W     = ((PW > ACC_W) ? PW : ACC_W) + 1;

  localparam logic signed [SUM_W-1:0] ACC_HI = SUM_W'({1'b0, {(ACC_W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] ACC_LO = -ACC_HI - 1;
  localparam logic signed [ACC_W-1:0] OUT_HI = ACC_W'({1'b0, {(OUT_W - 1){1'b1}}});
  localparam logic signed [ACC_W-1:0] OUT_LO = -OUT_HI - 1;

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] s);
    logic signed [ACC_W-1:0] r;
    if (s > ACC_HI) begin
      r = ACC_HI[ACC_W-1:0];
    end else if (s < ACC_LO) begin
      r = ACC_LO[ACC_W-1:0];
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] a);
    logic signed [OUT_W-1:0] r;
    if (a > OUT_HI) begin
      r = OUT_HI[OUT_W-1:0];
    end else if (a < OUT_LO) begin
      r = OUT_LO[OUT_W-1:0];
    end else begin
      r = a[OUT_W-1:0];
    end
    return r;
  endfunction

  // Queue entry fields.
  op_t                         q_op;
  logic [AW-1:0]               q_addr;
  logic [VALUE_BITS-1:0]       q_value;
  logic                        q_last;

  assign q_op    = op_t'(q_data[QW-1]);
  assign q_addr  = q_data[QW-2 -: AW];
  assign q_value = q_data[VALUE_BITS:1];
  assign q_last  = q_data[0];

  // Sequencer state.
  state_t                         st_r, st_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [RIW-1:0]                 row_r, row_nxt;
  logic [AW-1:0]                  addr_r, addr_nxt;
  logic signed [VALUE_BITS-1:0]   value_r, value_nxt;
  logic                           last_r, last_nxt;
  logic                           mis_r, mis_nxt;

  logic                           wt_we;
  logic                           issue_mac;
  logic                           issue_emit;
  logic                           clr_acc;
  logic [CNT_W-1:0]               count_inc;
  logic                           do_mac;
  logic                           last_row;

  // Storage and datapath registers.
  logic [VALUE_BITS-1:0]          wmem [ROWS * COLS];
  logic signed [ACC_W-1:0]        accm [ROWS];
  logic [ROWS-1:0]                accv_r;
  logic [VALUE_BITS-1:0]          wt_rd_r;
  logic signed [ACC_W-1:0]        acc_rd_r;
  logic                           accv_rd_r;
  logic                           b_vld_r;
  logic [RIW-1:0]                 b_row_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [ACC_W-1:0]        accd_r;
  logic                           c_vld_r;
  logic [RIW-1:0]                 c_row_r;
  logic signed [SUM_W-1:0]        sum;
  logic                           e1_vld_r;
  logic [RIW-1:0]                 e1_row_r;
  logic                           e1_last_r;
  logic                           e1_mis_r;
  result_t                        res_r;

  assign count_inc = (32'(count_r) < COUNT_MAX) ? count_r + 1'b1 : count_r;
  assign do_mac    = 32'(count_r) < 32'(ncols);
  assign last_row  = (32'(row_r) == 32'(nrows) - 1);

  always_comb begin
    st_nxt     = st_r;
    count_nxt  = count_r;
    row_nxt    = row_r;
    addr_nxt   = addr_r;
    value_nxt  = value_r;
    last_nxt   = last_r;
    mis_nxt    = mis_r;
    q_pop      = 1'b0;
    wt_we      = 1'b0;
    issue_mac  = 1'b0;
    issue_emit = 1'b0;
    clr_acc    = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op == OP_LOAD) begin
            wt_we = 1'b1;
          end else begin
            value_nxt = $signed(q_value);
            last_nxt  = q_last;
            count_nxt = count_inc;
            mis_nxt   = (32'(count_inc) != 32'(ncols));
            row_nxt   = '0;
            addr_nxt  = AW'(count_r);
            // Elements past the column count are only counted.
            if (do_mac) begin
              st_nxt = ST_MAC;
            end else if (q_last) begin
              st_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_MAC: begin
        issue_mac = 1'b1;
        row_nxt   = row_r + 1'b1;
        addr_nxt  = addr_r + AW'(COLS);
        if (last_row) begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!b_vld_r && !c_vld_r) begin
          row_nxt = '0;
          st_nxt  = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        issue_emit = 1'b1;
        row_nxt    = row_r + 1'b1;
        if (last_row) begin
          clr_acc   = 1'b1;
          count_nxt = '0;
          st_nxt    = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      count_r <= '0;
      row_r   <= '0;
      last_r  <= 1'b0;
      mis_r   <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      row_r   <= row_nxt;
      last_r  <= last_nxt;
      mis_r   <= mis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    value_r <= value_nxt;
  end

  // Weight store and accumulator memory, registered reads.
  always_ff @(posedge clk) begin
    if (wt_we) begin
      wmem[q_addr] <= q_value;
    end
    wt_rd_r <= wmem[addr_r];
  end

  assign sum = SUM_W'(accd_r) + SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (c_vld_r) begin
      accm[c_row_r] <= sat_acc(sum);
    end
    acc_rd_r <= accm[row_r];
  end

  // An accumulator that has not been written since the last result pass
  // reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accv_r <= '0;
    end else if (clr_acc) begin
      accv_r <= '0;
    end else if (c_vld_r) begin
      accv_r[c_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    accv_rd_r <= accv_r[row_r];
    b_row_r   <= row_r;
    prod_r    <= $signed(wt_rd_r) * value_r;
    accd_r    <= accv_rd_r ? acc_rd_r : '0;
    c_row_r   <= b_row_r;
    e1_row_r  <= row_r;
    e1_last_r <= last_row;
    e1_mis_r  <= mis_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      e1_vld_r    <= 1'b0;
      res_r.valid <= 1'b0;
    end else begin
      b_vld_r        <= issue_mac;
      c_vld_r        <= b_vld_r;
      e1_vld_r       <= issue_emit;
      res_r.valid    <= e1_vld_r;
      res_r.row      <= ROW_OUT_W'(e1_row_r);
      res_r.value    <= e1_mis_r ? '0 : sat_out(accv_rd_r ? acc_rd_r : '0);
      res_r.last     <= e1_last_r;
      res_r.mismatch <= e1_mis_r;
    end
  end

  assign res = res_r;

endmodule
